// ===== design/scft_pkg.sv =====
package scft_pkg;
  localparam int FRAME_COUNT = 64;
  localparam int FRAME_BITS = $clog2(FRAME_COUNT);
  localparam int COUNT_BITS = $clog2(FRAME_COUNT + 1);
  localparam int OWNER_BITS = 8;
  localparam int PAGE_BITS = 20;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_RES  = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_VICT_RD,
    S_VICT_GET,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIND_RD,
    S_FIND_CHK,
    S_APPEND,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]            mode;
    logic [OWNER_BITS-1:0] owner_id;
    logic [PAGE_BITS-1:0]  virtual_page;
    logic                  page_swap_backed;
    logic [5:0]            frame_number;
    logic                  is_write;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [5:0]            granted_frame;
    logic                  evicted;
    logic [OWNER_BITS-1:0] victim_owner;
    logic [PAGE_BITS-1:0]  victim_page;
    logic                  victim_swap_out;
  } rsp_t;
endpackage

// ===== design/scft_if.sv =====
interface scft_req_if;
  logic valid;
  logic ready;
  scft_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scft_rsp_if;
  logic valid;
  logic ready;
  scft_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/second_chance_frame_table_top.sv =====
// Frame table with second-chance replacement. One request at a time: access
// and not-resident requests check the frame's in-use bit, allocate takes a
// free frame when there is one, free searches the age order for the frame and
// then shifts the later entries down, and an eviction scans the age-order
// memory, up to two passes, then closes the gap, one memory access per step.
// Marks and in-use bits are flip-flops cleared by reset; tags and age order
// are in memories with a registered read.
module second_chance_frame_table_top (
  input  logic clk_i,
  input  logic rst_ni,
  scft_req_if.sink   req,
  scft_rsp_if.source rsp
);
  localparam int FB = scft_pkg::FRAME_BITS;
  localparam int CB = scft_pkg::COUNT_BITS;

  logic [FB-1:0] age_mem [scft_pkg::FRAME_COUNT];
  logic [scft_pkg::OWNER_BITS-1:0] own_mem [scft_pkg::FRAME_COUNT];
  logic [scft_pkg::PAGE_BITS-1:0] page_mem [scft_pkg::FRAME_COUNT];

  logic [scft_pkg::FRAME_COUNT-1:0] use_q, use_d, acc_q, acc_d, dirty_q, dirty_d;
  logic [scft_pkg::FRAME_COUNT-1:0] sb_q, sb_d;
  logic [CB-1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic pass2_q, pass2_d;
  logic [FB-1:0] frame_q, frame_d;
  scft_pkg::state_e st_q, st_d;
  scft_pkg::req_t r_q, r_d;
  scft_pkg::rsp_t o_q, o_d;

  logic age_we;
  logic [FB-1:0] age_wa, age_wd, age_ra, age_rd_q;
  logic [scft_pkg::OWNER_BITS-1:0] own_rd_q;
  logic [scft_pkg::PAGE_BITS-1:0] page_rd_q;
  logic tag_we;

  logic free_found;
  logic [FB-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = scft_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        free_found = 1'b1;
        free_idx = FB'(i);
      end
    end
  end

  logic fn_ok;
  assign fn_ok = ({26'd0, r_q.frame_number} < 32'(scft_pkg::FRAME_COUNT)) &&
                 use_q[FB'(r_q.frame_number)];

  always_ff @(posedge clk_i) begin
    if (age_we) age_mem[age_wa] <= age_wd;
    age_rd_q <= age_mem[age_ra];
    if (tag_we) begin
      own_mem[frame_q] <= r_q.owner_id;
      page_mem[frame_q] <= r_q.virtual_page;
    end
    own_rd_q <= own_mem[frame_q];
    page_rd_q <= page_mem[frame_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= scft_pkg::S_IDLE;
      use_q <= '0;
      acc_q <= '0;
      dirty_q <= '0;
      sb_q <= '0;
      cnt_q <= '0;
      pos_q <= '0;
      pass2_q <= 1'b0;
    end else begin
      st_q <= st_d;
      use_q <= use_d;
      acc_q <= acc_d;
      dirty_q <= dirty_d;
      sb_q <= sb_d;
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      pass2_q <= pass2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    o_q <= o_d;
    frame_q <= frame_d;
  end

  assign req.ready = (st_q == scft_pkg::S_IDLE);
  assign rsp.valid = (st_q == scft_pkg::S_OUT);
  assign rsp.data = o_q;

  always_comb begin
    st_d = st_q;
    use_d = use_q;
    acc_d = acc_q;
    dirty_d = dirty_q;
    sb_d = sb_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    pass2_d = pass2_q;
    r_d = r_q;
    o_d = o_q;
    frame_d = frame_q;
    age_we = 1'b0;
    age_wa = pos_q[FB-1:0];
    age_wd = age_rd_q;
    age_ra = pos_q[FB-1:0];
    tag_we = 1'b0;
    unique case (st_q)
      scft_pkg::S_IDLE: begin
        if (req.valid) begin
          r_d = req.data;
          o_d = '0;
          pos_d = '0;
          pass2_d = 1'b0;
          st_d = scft_pkg::S_FIND_CHK;
          unique case (scft_pkg::mode_e'(req.data.mode))
            scft_pkg::MODE_ALLOC: st_d = scft_pkg::S_SCAN_RD;
            scft_pkg::MODE_ACCESS, scft_pkg::MODE_FREE: st_d = scft_pkg::S_FIND_RD;
            default: st_d = scft_pkg::S_OUT;
          endcase
        end
      end
      scft_pkg::S_SCAN_RD: begin
        if (pos_q == '0 && free_found) begin
          frame_d = free_idx;
          st_d = scft_pkg::S_APPEND;
        end else if (pos_q == '0 && (cnt_q == '0)) begin
          o_d.status = scft_pkg::ST_NO_FRAME;
          st_d = scft_pkg::S_OUT;
        end else if (pos_q == cnt_q) begin
          pos_d = '0;
          pass2_d = 1'b1;
          st_d = scft_pkg::S_VICT_RD;
        end else begin
          st_d = scft_pkg::S_SCAN_CHK;
        end
      end
      scft_pkg::S_SCAN_CHK: begin
        if (!acc_q[age_rd_q]) begin
          frame_d = age_rd_q;
          st_d = scft_pkg::S_VICT_GET;
        end else begin
          acc_d[age_rd_q] = 1'b0;
          pos_d = pos_q + 1'b1;
          st_d = scft_pkg::S_SCAN_RD;
        end
      end
      scft_pkg::S_VICT_RD: st_d = scft_pkg::S_SCAN_CHK;
      scft_pkg::S_VICT_GET: begin
        // tag read of frame_q issues now and lands in the first shift read
        st_d = scft_pkg::S_SHIFT_RD;
        o_d.evicted = 1'b1;
        o_d.victim_swap_out = dirty_q[frame_q] | sb_q[frame_q];
        use_d[frame_q] = 1'b0;
        pos_d = pos_q + 1'b1;
      end
      scft_pkg::S_SHIFT_RD: begin
        if (o_q.evicted && o_q.victim_owner == '0 && o_q.victim_page == '0) begin
          o_d.victim_owner = own_rd_q;
          o_d.victim_page = page_rd_q;
        end
        if (pos_q >= cnt_q) begin
          cnt_d = cnt_q - 1'b1;
          st_d = (scft_pkg::mode_e'(r_q.mode) == scft_pkg::MODE_ALLOC) ?
                 scft_pkg::S_APPEND : scft_pkg::S_OUT;
        end else begin
          st_d = scft_pkg::S_SHIFT_WR;
        end
      end
      scft_pkg::S_SHIFT_WR: begin
        age_we = 1'b1;
        age_wa = FB'(pos_q - 1'b1);
        pos_d = pos_q + 1'b1;
        age_ra = FB'(pos_q + 1'b1);
        st_d = scft_pkg::S_SHIFT_RD;
      end
      scft_pkg::S_FIND_RD: begin
        if (!fn_ok) begin
          o_d.status = scft_pkg::ST_NOT_RES;
          st_d = scft_pkg::S_OUT;
        end else if (scft_pkg::mode_e'(r_q.mode) == scft_pkg::MODE_ACCESS) begin
          acc_d[FB'(r_q.frame_number)] = 1'b1;
          if (r_q.is_write) dirty_d[FB'(r_q.frame_number)] = 1'b1;
          st_d = scft_pkg::S_OUT;
        end else begin
          use_d[FB'(r_q.frame_number)] = 1'b0;
          acc_d[FB'(r_q.frame_number)] = 1'b0;
          dirty_d[FB'(r_q.frame_number)] = 1'b0;
          sb_d[FB'(r_q.frame_number)] = 1'b0;
          st_d = scft_pkg::S_FIND_CHK;
        end
      end
      scft_pkg::S_FIND_CHK: begin
        if (pos_q >= cnt_q) begin
          st_d = scft_pkg::S_OUT;
        end else if (age_rd_q == FB'(r_q.frame_number)) begin
          pos_d = pos_q + 1'b1;
          age_ra = FB'(pos_q + 1'b1);
          st_d = scft_pkg::S_SHIFT_RD;
        end else begin
          pos_d = pos_q + 1'b1;
          age_ra = FB'(pos_q + 1'b1);
        end
      end
      scft_pkg::S_APPEND: begin
        age_we = 1'b1;
        age_wa = cnt_q[FB-1:0];
        age_wd = frame_q;
        tag_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        use_d[frame_q] = 1'b1;
        acc_d[frame_q] = 1'b0;
        dirty_d[frame_q] = 1'b0;
        sb_d[frame_q] = r_q.page_swap_backed;
        o_d.granted_frame = 6'(frame_q);
        st_d = scft_pkg::S_OUT;
      end
      scft_pkg::S_OUT: begin
        if (rsp.ready) st_d = scft_pkg::S_IDLE;
      end
      default: st_d = scft_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CB'(scft_pkg::FRAME_COUNT))
    else $error("resident count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == scft_pkg::S_OUT && !rsp.ready) |=> $stable(o_q))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == scft_pkg::S_APPEND) |=> use_q[$past(frame_q)])
    else $error("granted frame not marked in use");
endmodule
